// ===== rtl/rbst_pkg.sv =====
package rbst_pkg;

    // Default sizes handed to the top level
    localparam int MAX_COLUMNS_DEF  = 256;
    localparam int MAX_SEGMENTS_DEF = 8;
    localparam int MAX_ROWS_DEF     = 1024;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_WIDTH = 2'd0,
        CFG_MIN_SEG   = 2'd1,
        CFG_MAX_GAP   = 2'd2,
        CFG_MAX_JUMP  = 2'd3
    } t_cfg_idx;

    localparam int ROW_WIDTH_W = 9;
    localparam int MIN_SEG_W   = 9;
    localparam int GAP_W       = 4;
    localparam int JUMP_W      = 8;

    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = 9'd240;
    localparam logic [MIN_SEG_W-1:0]   MIN_SEG_RST   = 9'd6;
    localparam logic [GAP_W-1:0]       MAX_GAP_RST   = 4'd3;
    localparam logic [JUMP_W-1:0]      MAX_JUMP_RST  = 8'd24;

    // Result field widths
    localparam int COORD_W   = 8;
    localparam int ROW_NUM_W = 10;

    // Per-pixel events from the run tracker to the segment picker
    typedef struct packed {
        logic close;
        logic row_end;
        logic frame_clear;
    } t_run_evt;

endpackage

// ===== rtl/rbst_run_tracker.sv =====
module rbst_run_tracker #(
    parameter int MAX_COLUMNS = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_is_black,
    input  logic                          i_frame_start,
    input  logic [$clog2(MAX_COLUMNS):0]  i_eff_width,
    input  logic [rbst_pkg::GAP_W-1:0]    i_max_gap,
    output rbst_pkg::t_run_evt            o_evt,
    output logic [$clog2(MAX_COLUMNS)-1:0] o_first,
    output logic [$clog2(MAX_COLUMNS)-1:0] o_last
);
    import rbst_pkg::*;

    localparam int COL_W  = $clog2(MAX_COLUMNS);
    localparam int GCNT_W = GAP_W + 1;

    logic [COL_W-1:0]  r_col, n_col;
    logic              r_open, n_open;
    logic [COL_W-1:0]  r_first, n_first;
    logic [COL_W-1:0]  r_last, n_last;
    logic [GCNT_W-1:0] r_gap, n_gap;

    logic [COL_W-1:0]  col0, first0, last0, cur_first, cur_last;
    logic              open0, gap_close, open_mid, row_end;
    logic [GCNT_W-1:0] gap0, gap_inc, gap_mid;
    logic [COL_W:0]    col_inc;

    always_comb begin
        // frame start clears tracking before the pixel is used
        col0   = i_frame_start ? '0 : r_col;
        open0  = i_frame_start ? 1'b0 : r_open;
        first0 = i_frame_start ? '0 : r_first;
        last0  = i_frame_start ? '0 : r_last;
        gap0   = i_frame_start ? '0 : r_gap;

        cur_first = (i_is_black && !open0) ? col0 : first0;
        cur_last  = i_is_black ? col0 : last0;

        gap_inc   = gap0 + GCNT_W'(1);
        gap_close = !i_is_black && open0 && (gap_inc > {1'b0, i_max_gap});
        open_mid  = i_is_black || (open0 && !gap_close);
        if (i_is_black || gap_close) begin
            gap_mid = '0;
        end else if (open0) begin
            gap_mid = gap_inc;
        end else begin
            gap_mid = gap0;
        end

        col_inc = {1'b0, col0} + (COL_W+1)'(1);
        row_end = !(col_inc < i_eff_width);

        o_evt.close       = gap_close || (row_end && open_mid);
        o_evt.row_end     = row_end;
        o_evt.frame_clear = i_frame_start;
        o_first           = cur_first;
        o_last            = cur_last;

        if (row_end) begin
            n_col   = '0;
            n_open  = 1'b0;
            n_gap   = '0;
            n_first = '0;
            n_last  = '0;
        end else begin
            n_col   = col_inc[COL_W-1:0];
            n_open  = open_mid;
            n_gap   = gap_mid;
            n_first = cur_first;
            n_last  = cur_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_open  <= 1'b0;
            r_first <= '0;
            r_last  <= '0;
            r_gap   <= '0;
        end else if (i_adv) begin
            r_col   <= n_col;
            r_open  <= n_open;
            r_first <= n_first;
            r_last  <= n_last;
            r_gap   <= n_gap;
        end
    end

endmodule

// ===== rtl/rbst_segment_picker.sv =====
module rbst_segment_picker #(
    parameter int MAX_COLUMNS  = 256,
    parameter int MAX_SEGMENTS = 8,
    parameter int MAX_ROWS     = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_adv,
    input  rbst_pkg::t_run_evt              i_evt,
    input  logic [$clog2(MAX_COLUMNS)-1:0]  i_first,
    input  logic [$clog2(MAX_COLUMNS)-1:0]  i_last,
    input  logic [$clog2(MAX_COLUMNS):0]    i_eff_width,
    input  logic [rbst_pkg::MIN_SEG_W-1:0]  i_min_width,
    input  logic [rbst_pkg::JUMP_W-1:0]     i_max_jump,
    output logic                            o_found,
    output logic [rbst_pkg::COORD_W-1:0]    o_start,
    output logic [rbst_pkg::COORD_W-1:0]    o_end,
    output logic [rbst_pkg::COORD_W-1:0]    o_center,
    output logic [rbst_pkg::ROW_NUM_W-1:0]  o_row_number
);
    import rbst_pkg::*;

    localparam int COL_W = $clog2(MAX_COLUMNS);
    localparam int SEG_W = $clog2(MAX_SEGMENTS + 1);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int MW    = (COL_W + 1 > MIN_SEG_W) ? COL_W + 1 : MIN_SEG_W;
    localparam int JW    = (COL_W > JUMP_W) ? COL_W : JUMP_W;

    typedef struct packed {
        logic             valid;
        logic [COL_W-1:0] ctr_off;
        logic [COL_W-1:0] first;
        logic [COL_W-1:0] last;
        logic [COL_W-1:0] ctr;
    } t_pick;

    logic [SEG_W-1:0] r_seen, n_seen;
    t_pick            r_near, n_near, r_any, n_any;
    logic [COL_W-1:0] r_prev, n_prev;
    logic             r_has_prev, n_has_prev;
    logic [ROW_W-1:0] r_row, n_row;

    logic [SEG_W-1:0] seen0, seen1;
    t_pick            near0, any0, near1, any1, cand, pick;
    logic [COL_W-1:0] prev0, ctr, ref_ctr, ctr_off;
    logic             has0, counts, near_ok;
    logic [ROW_W-1:0] row0;
    logic [COL_W:0]   run_w, sum;

    always_comb begin
        seen0 = i_evt.frame_clear ? '0 : r_seen;
        near0 = i_evt.frame_clear ? '0 : r_near;
        any0  = i_evt.frame_clear ? '0 : r_any;
        prev0 = i_evt.frame_clear ? '0 : r_prev;
        has0  = i_evt.frame_clear ? 1'b0 : r_has_prev;
        row0  = i_evt.frame_clear ? '0 : r_row;

        run_w  = {1'b0, i_last} - {1'b0, i_first} + (COL_W+1)'(1);
        counts = i_evt.close && (MW'(run_w) >= MW'(i_min_width))
                 && (seen0 < SEG_W'(MAX_SEGMENTS));

        sum     = {1'b0, i_first} + {1'b0, i_last};
        ctr     = sum[COL_W:1];
        // reference is the row middle until a center is chosen in this frame
        ref_ctr = has0 ? prev0 : i_eff_width[COL_W:1];
        ctr_off = (ctr > ref_ctr) ? ctr - ref_ctr : ref_ctr - ctr;
        near_ok = !has0 || (JW'(ctr_off) <= JW'(i_max_jump));

        cand = '{valid: 1'b1, ctr_off: ctr_off, first: i_first, last: i_last, ctr: ctr};

        near1 = (counts && near_ok && (!near0.valid || ctr_off < near0.ctr_off))
                ? cand : near0;
        any1  = (counts && (!any0.valid || ctr_off < any0.ctr_off)) ? cand : any0;
        seen1 = counts ? seen0 + SEG_W'(1) : seen0;

        pick    = near1.valid ? near1 : any1;
        o_found = pick.valid;
        o_start      = pick.valid ? COORD_W'(pick.first) : '0;
        o_end        = pick.valid ? COORD_W'(pick.last) : '0;
        o_center     = pick.valid ? COORD_W'(pick.ctr) : '0;
        o_row_number = ROW_NUM_W'(row0);

        if (i_evt.row_end) begin
            n_seen     = '0;
            n_near     = '0;
            n_any      = '0;
            n_row      = (row0 < ROW_W'(MAX_ROWS - 1)) ? row0 + ROW_W'(1) : row0;
            n_prev     = pick.valid ? pick.ctr : prev0;
            n_has_prev = has0 || pick.valid;
        end else begin
            n_seen     = seen1;
            n_near     = near1;
            n_any      = any1;
            n_row      = row0;
            n_prev     = prev0;
            n_has_prev = has0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= '0;
            r_near     <= '0;
            r_any      <= '0;
            r_prev     <= '0;
            r_has_prev <= 1'b0;
            r_row      <= '0;
        end else if (i_adv) begin
            r_seen     <= n_seen;
            r_near     <= n_near;
            r_any      <= n_any;
            r_prev     <= n_prev;
            r_has_prev <= n_has_prev;
            r_row      <= n_row;
        end
    end

endmodule

// ===== rtl/row_black_segment_tracker_top.sv =====
// Row black segment tracker.
// Input channel (i_valid / o_ready): one classified pixel per request, row
// order, left to right; i_frame_start marks column 0 of row 0 of a frame.
// Output channel (o_valid / i_ready): one result per row, issued for the
// row's last pixel: the chosen segment's bounds and center, or o_row_found
// low with zero bounds, plus the row index.
// Configuration: i_cfg_we writes i_cfg_data into the register at i_cfg_idx
// (row width, min segment width, max white gap, max center jump); write
// only while the block is idle.
// Throughput: one pixel per cycle unless a result waits for i_ready. The run
// tracker and segment picker update their state for each pixel between the input
// register and the result register.
// A row's result loads into the result register when the row's last pixel leaves
// the input register, and o_valid shows it from that register.
// Reset: configuration returns to 240 / 6 / 3 / 24, all tracking clears.
// Stall: while a result waits for i_ready, a pixel in the input register
// holds and o_ready stays low; an empty input register still takes one pixel.
module row_black_segment_tracker_top #(
    parameter int MAX_COLUMNS  = rbst_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_SEGMENTS = rbst_pkg::MAX_SEGMENTS_DEF,
    parameter int MAX_ROWS     = rbst_pkg::MAX_ROWS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rbst_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rbst_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_is_black,
    input  logic                             i_frame_start,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_row_found,
    output logic [rbst_pkg::COORD_W-1:0]     o_seg_start,
    output logic [rbst_pkg::COORD_W-1:0]     o_segment_end,
    output logic [rbst_pkg::COORD_W-1:0]     o_segment_center,
    output logic [rbst_pkg::ROW_NUM_W-1:0]   o_row_number
);
    import rbst_pkg::*;

    localparam int COL_W = $clog2(MAX_COLUMNS);
    localparam int EW_W  = (COL_W + 1 > ROW_WIDTH_W) ? COL_W + 1 : ROW_WIDTH_W;

    logic [ROW_WIDTH_W-1:0] r_row_width;
    logic [MIN_SEG_W-1:0]   r_min_seg;
    logic [GAP_W-1:0]       r_max_gap;
    logic [JUMP_W-1:0]      r_max_jump;

    logic r_in_valid, r_in_black, r_in_fs;
    logic r_out_valid;
    logic r_found;
    logic [COORD_W-1:0]   r_start, r_end, r_center;
    logic [ROW_NUM_W-1:0] r_row_num;

    logic                 adv, out_free;
    logic [COL_W:0]       eff_width;
    t_run_evt             evt;
    logic [COL_W-1:0]     run_first, run_last;
    logic                 pk_found;
    logic [COORD_W-1:0]   pk_start, pk_end, pk_center;
    logic [ROW_NUM_W-1:0] pk_row;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= ROW_WIDTH_RST;
            r_min_seg   <= MIN_SEG_RST;
            r_max_gap   <= MAX_GAP_RST;
            r_max_jump  <= MAX_JUMP_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ROW_WIDTH: r_row_width <= i_cfg_data[ROW_WIDTH_W-1:0];
                CFG_MIN_SEG:   r_min_seg   <= i_cfg_data[MIN_SEG_W-1:0];
                CFG_MAX_GAP:   r_max_gap   <= i_cfg_data[GAP_W-1:0];
                CFG_MAX_JUMP:  r_max_jump  <= i_cfg_data[JUMP_W-1:0];
            endcase
        end
    end

    // Clamp row width into 1 .. MAX_COLUMNS
    always_comb begin
        if (r_row_width == '0) begin
            eff_width = (COL_W+1)'(1);
        end else if (EW_W'(r_row_width) > EW_W'(MAX_COLUMNS)) begin
            eff_width = (COL_W+1)'(MAX_COLUMNS);
        end else begin
            eff_width = (COL_W+1)'(r_row_width);
        end
    end

    assign out_free = !r_out_valid || i_ready;
    assign adv      = r_in_valid && out_free;
    assign o_ready  = !r_in_valid || adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_black <= i_is_black;
            r_in_fs    <= i_frame_start;
        end
    end

    rbst_run_tracker #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_tracker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_is_black    (r_in_black),
        .i_frame_start (r_in_fs),
        .i_eff_width   (eff_width),
        .i_max_gap     (r_max_gap),
        .o_evt         (evt),
        .o_first       (run_first),
        .o_last        (run_last)
    );

    rbst_segment_picker #(
        .MAX_COLUMNS  (MAX_COLUMNS),
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .MAX_ROWS     (MAX_ROWS)
    ) u_picker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_evt        (evt),
        .i_first      (run_first),
        .i_last       (run_last),
        .i_eff_width  (eff_width),
        .i_min_width  (r_min_seg),
        .i_max_jump   (r_max_jump),
        .o_found      (pk_found),
        .o_start      (pk_start),
        .o_end        (pk_end),
        .o_center     (pk_center),
        .o_row_number (pk_row)
    );

    // Result register: load at row end, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && evt.row_end) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && evt.row_end) begin
            r_found   <= pk_found;
            r_start   <= pk_start;
            r_end     <= pk_end;
            r_center  <= pk_center;
            r_row_num <= pk_row;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_row_found      = r_found;
    assign o_seg_start      = r_start;
    assign o_segment_end    = r_end;
    assign o_segment_center = r_center;
    assign o_row_number     = r_row_num;

endmodule

// ===== dv/tb_row_black_segment_tracker_top.sv =====
`timescale 1ns / 1ps

module tb_row_black_segment_tracker_top;
    import rbst_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int SETTLE_TICKS = 6;

    typedef struct packed {
        bit black;
        bit frame_start;
    } t_pixel;

    typedef struct packed {
        bit               valid;
        bit [COORD_W-1:0] distance;
        bit [COORD_W-1:0] first;
        bit [COORD_W-1:0] last;
    } t_seg_pick;

    typedef struct packed {
        bit                 found;
        bit [COORD_W-1:0]   first;
        bit [COORD_W-1:0]   last;
        bit [COORD_W-1:0]   center;
        bit [ROW_NUM_W-1:0] row;
    } t_row_pick;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  i_valid       = 1'b0;
    logic                  i_is_black    = 1'b0;
    logic                  i_frame_start = 1'b0;
    logic                  i_ready       = 1'b0;
    logic                  o_ready;
    logic                  o_valid;
    logic                  o_row_found;
    logic [COORD_W-1:0]    o_seg_start;
    logic [COORD_W-1:0]    o_segment_end;
    logic [COORD_W-1:0]    o_segment_center;
    logic [ROW_NUM_W-1:0]  o_row_number;

    row_black_segment_tracker_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_is_black       (i_is_black),
        .i_frame_start    (i_frame_start),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_row_found      (o_row_found),
        .o_seg_start      (o_seg_start),
        .o_segment_end    (o_segment_end),
        .o_segment_center (o_segment_center),
        .o_row_number     (o_row_number)
    );

    t_pixel    pending_pixels[$];
    t_row_pick expected_picks[$];
    int        mismatches = 0;
    int        idle_cycles = 0;
    int        pix_gap = 0, pix_calm = 0;
    int        rdy_stall = 0, rdy_calm = 0;

    // Configuration as the block should hold it
    bit [ROW_WIDTH_W-1:0] cfg_row_width = ROW_WIDTH_RST;
    bit [MIN_SEG_W-1:0]   cfg_min_width = MIN_SEG_RST;
    bit [GAP_W-1:0]       cfg_max_gap   = MAX_GAP_RST;
    bit [JUMP_W-1:0]      cfg_max_jump  = MAX_JUMP_RST;

    // Tracking state
    bit [COORD_W-1:0]   col_cnt = '0;
    bit [ROW_NUM_W-1:0] row_cnt = '0;
    bit                 run_open = 1'b0;
    bit [COORD_W-1:0]   run_first = '0;
    bit [COORD_W-1:0]   run_last = '0;
    bit [4:0]           gap_cnt = '0;
    bit [3:0]           seg_cnt = '0;
    t_seg_pick          near_pick = '0;
    t_seg_pick          any_pick = '0;
    bit [COORD_W-1:0]   prev_center = '0;
    bit                 has_prev = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit [ROW_WIDTH_W-1:0] eff_width();
        if (cfg_row_width == 0) return 1;
        if (cfg_row_width > ROW_WIDTH_W'(MAX_COLUMNS_DEF)) return ROW_WIDTH_W'(MAX_COLUMNS_DEF);
        return cfg_row_width;
    endfunction

    function automatic bit [COORD_W-1:0] mid_col(input bit [COORD_W-1:0] a,
                                                  input bit [COORD_W-1:0] b);
        bit [COORD_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[COORD_W:1];
    endfunction

    task automatic reset_row_track();
        run_open  = 1'b0;
        run_first = '0;
        run_last  = '0;
        gap_cnt   = '0;
        seg_cnt   = '0;
        near_pick = '0;
        any_pick  = '0;
    endtask

    task automatic reset_frame_track();
        reset_row_track();
        col_cnt     = '0;
        row_cnt     = '0;
        prev_center = '0;
        has_prev    = 1'b0;
    endtask

    task automatic offer(inout t_seg_pick pick, input bit [COORD_W-1:0] distance,
                         input bit [COORD_W-1:0] first, input bit [COORD_W-1:0] last);
        if (!pick.valid || distance < pick.distance)
            pick = '{1'b1, distance, first, last};
    endtask

    task automatic close_run();
        bit [COORD_W:0]   span;
        bit [COORD_W-1:0] center;
        bit [COORD_W-1:0] anchor;
        bit [COORD_W-1:0] distance;
        run_open = 1'b0;
        gap_cnt  = '0;
        if (run_last < run_first) return;
        span = {1'b0, run_last} - {1'b0, run_first} + 1'b1;
        if (span < cfg_min_width) return;
        if (seg_cnt >= 4'(MAX_SEGMENTS_DEF)) return;
        seg_cnt++;
        center   = mid_col(run_first, run_last);
        anchor   = has_prev ? prev_center : COORD_W'(eff_width() >> 1);
        distance = center > anchor ? center - anchor : anchor - center;
        if (!has_prev || distance <= cfg_max_jump)
            offer(near_pick, distance, run_first, run_last);
        offer(any_pick, distance, run_first, run_last);
    endtask

    // Advance the tracker by one pixel; queue the row pick at each row end
    task automatic predict_pixel(input bit black, input bit frame_start);
        bit [ROW_WIDTH_W-1:0] width;
        bit [COORD_W-1:0]     col;
        t_seg_pick            chosen;
        t_row_pick            pick;
        width = eff_width();
        if (frame_start) reset_frame_track();
        col = col_cnt;
        if (black) begin
            if (!run_open) begin
                run_open  = 1'b1;
                run_first = col;
            end
            run_last = col;
            gap_cnt  = '0;
        end else if (run_open) begin
            gap_cnt++;
            if (gap_cnt > {1'b0, cfg_max_gap}) close_run();
        end
        if ({1'b0, col} + 1'b1 < width) begin
            col_cnt = col + 1'b1;
            return;
        end
        if (run_open) close_run();
        chosen = near_pick.valid ? near_pick : any_pick;
        pick = '0;
        if (chosen.valid) begin
            pick.found  = 1'b1;
            pick.first  = chosen.first;
            pick.last   = chosen.last;
            pick.center = mid_col(chosen.first, chosen.last);
            prev_center = pick.center;
            has_prev    = 1'b1;
        end
        pick.row = row_cnt;
        expected_picks.push_back(pick);
        reset_row_track();
        col_cnt = '0;
        if (row_cnt < ROW_NUM_W'(MAX_ROWS_DEF - 1)) row_cnt++;
    endtask

    // Mostly short gaps, a few long ones, and now and then a stretch with none
    task automatic draw_gap(inout int calm, output int gap);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm > 0) begin
            calm--;
            gap = 0;
        end else if (roll < 2) begin
            calm = $urandom_range(30, 200);
            gap  = 0;
        end else if (roll < 70) begin
            gap = 0;
        end else if (roll < 94) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(8, 40);
        end
    endtask

    always @(posedge i_clk) begin : pixel_driver
        t_pixel nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) predict_pixel(i_is_black, i_frame_start);
            // hold the request until it is taken
            if (!i_valid || o_ready) begin
                if (pix_gap > 0) begin
                    pix_gap--;
                    i_valid <= 1'b0;
                end else if (pending_pixels.size() > 0) begin
                    nxt = pending_pixels.pop_front();
                    i_valid       <= 1'b1;
                    i_is_black    <= nxt.black;
                    i_frame_start <= nxt.frame_start;
                    draw_gap(pix_calm, pix_gap);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    task automatic compare_field(input string what, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d got %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : row_monitor
        t_row_pick want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_picks.size() == 0) begin
                    $display("%0t: row result expected none got row_number %0d",
                             $time, o_row_number);
                    mismatches++;
                end else begin
                    want = expected_picks.pop_front();
                    compare_field("row_found", want.found, o_row_found);
                    compare_field("seg_start", want.first, o_seg_start);
                    compare_field("segment_end", want.last, o_segment_end);
                    compare_field("segment_center", want.center, o_segment_center);
                    compare_field("row_number", want.row, o_row_number);
                end
            end
            if (rdy_stall > 0) begin
                rdy_stall--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                draw_gap(rdy_calm, rdy_stall);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_pixels.size() != 0 || i_valid || expected_picks.size() != 0)
            @(negedge i_clk);
        // let a dropped partial row drain through the pipeline
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_cfg(input t_cfg_idx idx, input int value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(value);
        case (idx)
            CFG_ROW_WIDTH: cfg_row_width = ROW_WIDTH_W'(value);
            CFG_MIN_SEG:   cfg_min_width = MIN_SEG_W'(value);
            CFG_MAX_GAP:   cfg_max_gap   = GAP_W'(value);
            CFG_MAX_JUMP:  cfg_max_jump  = JUMP_W'(value);
            default: ;
        endcase
    endtask

    task automatic set_phase(input int row_width, input int min_width,
                             input int max_gap, input int max_jump);
        wait_idle();
        write_cfg(CFG_ROW_WIDTH, row_width);
        write_cfg(CFG_MIN_SEG, min_width);
        write_cfg(CFG_MAX_GAP, max_gap);
        write_cfg(CFG_MAX_JUMP, max_jump);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // '#' is black, '.' is white; frame_start goes on the first pixel only
    task automatic push_pattern(input string pattern, input bit frame_start);
        for (int k = 0; k < pattern.len(); k++)
            pending_pixels.push_back('{pattern[k] == "#", frame_start && k == 0});
    endtask

    // Rows of runs and gaps sized around the current limits, with noise rows,
    // blank and solid rows, new frames and rows cut short by a frame start
    task automatic gen_rows(input int rows, input bit fresh, input bit breaks,
                            input int tail);
        int width, col, cut, style, len, lo;
        bit fs_next, black;
        width   = eff_width();
        fs_next = fresh;
        for (int r = 0; r < rows; r++) begin
            style = $urandom_range(0, 9);
            cut   = width;
            if (breaks && $urandom_range(0, 24) == 0) fs_next = 1'b1;
            if (breaks && $urandom_range(0, 29) == 0) cut = $urandom_range(1, width);
            col   = 0;
            black = $urandom_range(0, 1);
            while (col < cut) begin
                case (style)
                    0: begin
                        len   = 1;
                        black = $urandom_range(0, 1);
                    end
                    1: begin
                        len   = cut - col;
                        black = 1'b0;
                    end
                    2: begin
                        len   = cut - col;
                        black = 1'b1;
                    end
                    default: begin
                        if (black) begin
                            lo  = cfg_min_width > 2 ? cfg_min_width - 2 : 1;
                            len = $urandom_range(0, 4) == 0 ? $urandom_range(1, 3)
                                                            : $urandom_range(lo, lo + 6);
                        end else if (cfg_max_gap == 0 || $urandom_range(0, 1)) begin
                            len = $urandom_range(cfg_max_gap + 1, cfg_max_gap + 4);
                        end else begin
                            len = $urandom_range(1, cfg_max_gap);
                        end
                    end
                endcase
                for (int k = 0; k < len && col < cut; k++) begin
                    pending_pixels.push_back('{black, fs_next});
                    fs_next = 1'b0;
                    col++;
                end
                black = !black;
            end
            // a cut row is dropped by the frame start that follows
            if (cut < width) fs_next = 1'b1;
        end
        repeat (tail) pending_pixels.push_back('{1'($urandom_range(0, 1)), 1'b0});
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows, six columns wide, middle at column 3
        set_phase(6, 2, 1, 1);
        push_pattern("..##..", 1'b1);  // narrowest counted run on the first row
        push_pattern("##..##", 1'b0);  // both beyond the jump, equal distance
        push_pattern("#....#", 1'b0);  // runs too narrow: nothing found
        push_pattern("###", 1'b0);     // partial row, dropped below
        push_pattern("#.#.#.", 1'b1);  // bridged gaps after a new frame

        set_phase(24, 4, 3, 10);
        gen_rows(5, 1'b1, 1'b1, 20);
        // narrower rows while a partial row is held: next pixel ends it
        set_phase(16, 3, 2, 4);
        gen_rows(8, 1'b0, 1'b1, 0);
        // width zero acts as one: every pixel is a row, drive the row count into saturation
        set_phase(0, 0, 0, 0);
        gen_rows(1028, 1'b1, 1'b0, 0);
        // width above the column count, full-width segment
        set_phase(511, 256, 15, 255);
        for (int k = 0; k < MAX_COLUMNS_DEF; k++)
            pending_pixels.push_back('{1'b1, k == 0});
        set_phase(13, 1, 15, 0);
        gen_rows(6, 1'b1, 1'b1, 0);
        set_phase(32, 6, 3, 24);
        gen_rows(3, 1'b1, 1'b1, 0);

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && expected_picks.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
